// ===== hdl/snoop_coherence_mesi_moesi_macros.svh =====
// Assertion macros shared by the coherence block.
`ifndef SNOOP_COHERENCE_MESI_MOESI_MACROS_SVH
`define SNOOP_COHERENCE_MESI_MOESI_MACROS_SVH

// Check an implication every clock, quiet during reset.
`define SCM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// Check that the consequence holds in the cycle after the antecedent.
`define SCM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

// ===== hdl/scm_pkg.sv =====
`timescale 1ns / 1ps
package scm_pkg;

   localparam int CORES_DEF     = 4;
   localparam int LINES_DEF     = 4;
   localparam int MEM_WORDS_DEF = 16;
   localparam int DATA_BITS_DEF = 32;

   localparam logic [1:0] KIND_READ    = 2'd0;
   localparam logic [1:0] KIND_WRITE   = 2'd1;
   localparam logic [1:0] KIND_PRELOAD = 2'd2;

   localparam logic [2:0] ST_I = 3'd0;
   localparam logic [2:0] ST_S = 3'd1;
   localparam logic [2:0] ST_E = 3'd2;
   localparam logic [2:0] ST_O = 3'd3;
   localparam logic [2:0] ST_M = 3'd4;

   localparam logic [1:0] FILL_MEM    = 2'd0;
   localparam logic [1:0] FILL_REMOTE = 2'd1;
   localparam logic [1:0] FILL_NONE   = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         core;
      logic [3:0]         address;
      logic signed [31:0] data;
   } req_type;

   typedef struct packed {
      logic signed [31:0] line_data;
      logic [2:0]         line_state;
      logic               local_hit;
      logic [3:0]         holder_mask;
      logic [1:0]         fill_source;
      logic [1:0]         source_cache;
      logic [2:0]         writebacks;
      logic [2:0]         invalidations;
   } rsp_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_SNOOP,
      CTL_UPDATE,
      CTL_FILL,
      CTL_RESPOND
   } ctl_state_type;

   typedef struct packed {
      logic load;
      logic snoop;
      logic update;
      logic fill;
      logic respond;
   } ctl_cmd_type;

   typedef struct packed {
      logic preload;
      logic rsp_busy;
   } ctl_status_type;

endpackage

// ===== hdl/scm_ctrl.sv =====
`timescale 1ns / 1ps
module scm_ctrl
   import scm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  ctl_status_type status,
   output ctl_cmd_type    cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            if (req_valid) state_in = CTL_SNOOP;
         end
         CTL_SNOOP: begin
            state_in = status.preload ? CTL_FILL : CTL_UPDATE;
         end
         CTL_UPDATE: state_in = CTL_FILL;
         CTL_FILL: state_in = CTL_RESPOND;
         CTL_RESPOND: begin
            if (!status.rsp_busy) state_in = CTL_IDLE;
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         CTL_IDLE: begin
            req_stall = 1'b0;
            cmd.load = req_valid;
         end
         CTL_SNOOP:   cmd.snoop = 1'b1;
         CTL_UPDATE:  cmd.update = 1'b1;
         CTL_FILL:    cmd.fill = 1'b1;
         CTL_RESPOND: cmd.respond = !status.rsp_busy;
         default: ;
      endcase
   end

endmodule

// ===== hdl/scm_datapath.sv =====
`timescale 1ns / 1ps
module scm_datapath
   import scm_pkg::*;
#(
   parameter int CORES     = CORES_DEF,
   parameter int LINES     = LINES_DEF,
   parameter int MEM_WORDS = MEM_WORDS_DEF,
   parameter int DATA_BITS = DATA_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           mode,
   input  req_type        req,
   input  ctl_cmd_type    cmd,
   output ctl_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp
);

   localparam int CW = (CORES > 1) ? $clog2(CORES) : 1;
   localparam int LW = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

   logic [AW-1:0]        tag_ff    [CORES][LINES];
   logic [2:0]           stat_ff   [CORES][LINES];
   logic                 dirty_ff  [CORES][LINES];
   logic [DATA_BITS-1:0] value_ff  [CORES][LINES];
   logic [DATA_BITS-1:0] mem [MEM_WORDS];

   logic [1:0]           kind_ff;
   logic [CW-1:0]        core_ff;
   logic [AW-1:0]        addr_ff;
   logic [LW-1:0]        idx_ff;
   logic [DATA_BITS-1:0] data_ff;
   logic                 hit_ff;
   logic [CORES-1:0]     mask_ff;
   logic [CW-1:0]        first_ff;
   logic [2:0]           wb_ff, inv_ff;
   logic [DATA_BITS-1:0] memrd_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   logic [CORES-1:0] mask_in;
   logic [CW-1:0]    first_in;
   logic             hit_in;

   logic [CW-1:0]        core_in;
   logic [AW-1:0]        addr_in;
   logic [DATA_BITS-1:0] data_in;

   assign core_in = CW'(32'(req.core) % CORES);
   assign addr_in = AW'(32'(req.address) % MEM_WORDS);
   assign data_in = DATA_BITS'(64'(signed'(req.data)));

   always_comb begin
      mask_in = '0;
      first_in = '0;
      for (int i = CORES - 1; i >= 0; i--) begin
         if (CW'(i) != core_ff && stat_ff[i][idx_ff] != ST_I
             && tag_ff[i][idx_ff] == addr_ff) begin
            mask_in[i] = 1'b1;
            first_in = CW'(i);
         end
      end
      hit_in = stat_ff[core_ff][idx_ff] != ST_I && tag_ff[core_ff][idx_ff] == addr_ff;
   end

   // Write-back on leaving a state toward Invalid.
   function automatic logic flush_inv(logic m, logic [2:0] st, logic d);
      flush_inv = (m == 1'b0) ? d : (d && st != ST_S);
   endfunction

   logic             vic_valid, vic_flush;
   logic [CORES-1:0] upd_inv, upd_flush;
   logic [2:0]       wb_cnt, inv_cnt;
   logic             do_remote;

   always_comb begin
      do_remote = !hit_ff && mask_ff != '0;
      upd_inv   = '0;
      upd_flush = '0;
      for (int i = 0; i < CORES; i++) begin
         if (mask_ff[i]) begin
            if (kind_ff == KIND_WRITE) begin
               upd_inv[i] = 1'b1;
               upd_flush[i] = flush_inv(mode, stat_ff[i][idx_ff], dirty_ff[i][idx_ff]);
            end else if (do_remote && stat_ff[i][idx_ff] != ST_S && mode == 1'b0) begin
               upd_flush[i] = dirty_ff[i][idx_ff];
            end
         end
      end
      vic_valid = !hit_ff && stat_ff[core_ff][idx_ff] != ST_I;
      vic_flush = vic_valid
                  && flush_inv(mode, stat_ff[core_ff][idx_ff], dirty_ff[core_ff][idx_ff]);
      wb_cnt  = 3'($countones(upd_flush)) + 3'(vic_flush);
      inv_cnt = 3'($countones(upd_inv)) + 3'(vic_valid);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req.kind;
         core_ff <= core_in;
         addr_ff <= addr_in;
         idx_ff  <= LW'(32'(addr_in) % LINES);
         data_ff <= data_in;
      end
      if (cmd.snoop) begin
         mask_ff  <= mask_in;
         first_ff <= first_in;
         hit_ff   <= hit_in;
      end
      if (cmd.update) begin
         wb_ff  <= wb_cnt;
         inv_ff <= inv_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CORES; c++) begin
            for (int l = 0; l < LINES; l++) begin
               tag_ff[c][l]   <= '0;
               stat_ff[c][l]  <= ST_I;
               dirty_ff[c][l] <= 1'b0;
               value_ff[c][l] <= '0;
            end
         end
      end else if (cmd.update && kind_ff <= KIND_WRITE) begin
         for (int i = 0; i < CORES; i++) begin
            if (mask_ff[i]) begin
               if (kind_ff == KIND_WRITE) begin
                  stat_ff[i][idx_ff]  <= ST_I;
                  dirty_ff[i][idx_ff] <= 1'b0;
               end else if (do_remote && stat_ff[i][idx_ff] != ST_S) begin
                  if (mode == 1'b0) begin
                     stat_ff[i][idx_ff]  <= ST_S;
                     dirty_ff[i][idx_ff] <= 1'b0;
                  end else if (stat_ff[i][idx_ff] == ST_E) begin
                     stat_ff[i][idx_ff] <= ST_S;
                  end else begin
                     stat_ff[i][idx_ff] <= ST_O;
                  end
               end
            end
         end
         if (kind_ff == KIND_WRITE) begin
            tag_ff[core_ff][idx_ff]   <= addr_ff;
            stat_ff[core_ff][idx_ff]  <= ST_M;
            dirty_ff[core_ff][idx_ff] <= 1'b1;
            value_ff[core_ff][idx_ff] <= data_ff;
         end else if (do_remote) begin
            tag_ff[core_ff][idx_ff]   <= addr_ff;
            stat_ff[core_ff][idx_ff]  <= ST_S;
            dirty_ff[core_ff][idx_ff] <= mode && dirty_ff[first_ff][idx_ff];
            value_ff[core_ff][idx_ff] <= value_ff[first_ff][idx_ff];
         end
      end else if (cmd.fill && kind_ff == KIND_READ && !hit_ff && mask_ff == '0) begin
         tag_ff[core_ff][idx_ff]   <= addr_ff;
         stat_ff[core_ff][idx_ff]  <= ST_E;
         dirty_ff[core_ff][idx_ff] <= 1'b0;
         value_ff[core_ff][idx_ff] <= memrd_ff;
      end
   end

   logic                 remote_wb_ff;
   logic [DATA_BITS-1:0] remote_val_ff;
   logic [DATA_BITS-1:0] remote_val;

   // Memory: one write port, one registered read; flushed lines go out one per cycle.
   logic             mem_we;
   logic [AW-1:0]    mem_wa;
   logic [DATA_BITS-1:0] mem_wd;

   always_comb begin
      mem_we = 1'b0;
      mem_wa = addr_ff;
      mem_wd = data_ff;
      if (cmd.snoop && kind_ff == KIND_PRELOAD) begin
         mem_we = 1'b1;
      end else if (cmd.update) begin
         // All flushed lines hold the same word except the victim; the
         // victim's tag differs, remote copies share the requested tag.
         if (vic_flush) begin
            mem_we = 1'b1;
            mem_wa = tag_ff[core_ff][idx_ff];
            mem_wd = value_ff[core_ff][idx_ff];
         end
      end else if (cmd.fill && remote_wb_ff) begin
         mem_we = 1'b1;
         mem_wa = addr_ff;
         mem_wd = remote_val_ff;
      end
   end

   always_comb begin
      remote_val = '0;
      for (int i = CORES - 1; i >= 0; i--) begin
         if (upd_flush[i]) remote_val = value_ff[i][idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remote_wb_ff <= 1'b0;
      end else if (cmd.update) begin
         remote_wb_ff <= upd_flush != '0;
      end else if (cmd.fill) begin
         remote_wb_ff <= 1'b0;
      end
      if (cmd.update) remote_val_ff <= remote_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < MEM_WORDS; w++) begin
            mem[w] <= '0;
         end
      end else if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      memrd_ff <= mem[addr_ff];
   end

   rsp_type rsp_in;
   always_comb begin
      rsp_in = '0;
      rsp_in.fill_source = FILL_NONE;
      if (kind_ff <= KIND_WRITE) begin
         rsp_in.line_data     = 32'(value_ff[core_ff][idx_ff]);
         rsp_in.line_state    = stat_ff[core_ff][idx_ff];
         rsp_in.local_hit     = hit_ff;
         rsp_in.holder_mask   = 4'(mask_ff);
         rsp_in.writebacks    = wb_ff;
         rsp_in.invalidations = inv_ff;
         if (kind_ff == KIND_READ && !hit_ff) begin
            rsp_in.fill_source  = (mask_ff != '0) ? FILL_REMOTE : FILL_MEM;
            rsp_in.source_cache = (mask_ff != '0) ? 2'(first_ff) : 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.respond) rsp_ff <= rsp_in;
   end

   assign status.preload  = kind_ff[1];
   assign status.rsp_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

// ===== hdl/snoop_coherence_mesi_moesi.sv =====
`timescale 1ns / 1ps
// Requests are handled one at a time: a new one is taken only in idle, after the
// last response has been loaded for output. The controller sequences snoop, line
// update (not for preload), memory fill and response through one memory port.
// Reset: synchronous; all lines Invalid, memory words zero, mode MESI.
module snoop_coherence_mesi_moesi
   import scm_pkg::*;
#(
   parameter int CORES     = CORES_DEF,
   parameter int LINES     = LINES_DEF,
   parameter int MEM_WORDS = MEM_WORDS_DEF,
   parameter int DATA_BITS = DATA_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

`include "snoop_coherence_mesi_moesi_macros.svh"

   logic           mode_ff;
   ctl_cmd_type    cmd;
   ctl_status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         mode_ff <= csr_data;
      end
   end

   scm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   scm_datapath #(
      .CORES     (CORES),
      .LINES     (LINES),
      .MEM_WORDS (MEM_WORDS),
      .DATA_BITS (DATA_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .req       (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp_data)
   );

   `SCM_ASSERT_IMP(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd))
   `SCM_ASSERT_NEXT(a_load_stalls, clock, reset, cmd.load, req_stall)
   `SCM_ASSERT_NEXT(a_respond_valid, clock, reset, cmd.respond, rsp_valid)

endmodule

// ===== tb/snoop_coherence_mesi_moesi_checker.sv =====
`timescale 1ns / 1ps
module snoop_coherence_mesi_moesi_checker
   import scm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   input  logic    csr_valid,
   input  logic    csr_ready,
   input  logic    csr_data,
   output int      failures,
   output int      pending
);

   logic [3:0]  tag_of   [16];
   logic [2:0]  state_of [16];
   logic        dirty_of [16];
   logic [31:0] value_of [16];
   logic [31:0] memory   [16];
   logic        moesi;
   int          wb_count;
   int          inv_count;
   rsp_type     expected_rsps[$];

   function automatic void leave_line(int slot, logic [2:0] target);
      logic flush;
      if (state_of[slot] == ST_I) return;
      if (target == ST_I) inv_count++;
      if (!moesi) flush = dirty_of[slot];
      else flush = dirty_of[slot] && target == ST_I && state_of[slot] != ST_S;
      if (flush) begin
         memory[tag_of[slot]] = value_of[slot];
         wb_count++;
      end
   endfunction

   function automatic rsp_type coherence_result(req_type r);
      rsp_type    res;
      int         idx, mine, first, fs, s;
      logic [3:0] mask;
      logic       hit, any, dd;
      logic [31:0] v;
      res = '0;
      res.fill_source = FILL_NONE;
      if (r.kind != KIND_READ && r.kind != KIND_WRITE) begin
         if (r.kind == KIND_PRELOAD) memory[r.address] = r.data;
         return res;
      end
      wb_count = 0;
      inv_count = 0;
      idx = r.address[1:0];
      mine = r.core * 4 + idx;
      mask = '0;
      first = 0;
      any = 1'b0;
      hit = state_of[mine] != ST_I && tag_of[mine] == r.address;
      for (int i = 0; i < 4; i++) begin
         s = i * 4 + idx;
         if (i != r.core && state_of[s] != ST_I && tag_of[s] == r.address) begin
            if (!any) first = i;
            any = 1'b1;
            mask[i] = 1'b1;
         end
      end
      if (r.kind == KIND_READ) begin
         if (!hit && any) begin
            fs = first * 4 + idx;
            v = value_of[fs];
            dd = moesi && dirty_of[fs];
            for (int i = 0; i < 4; i++) begin
               s = i * 4 + idx;
               if (mask[i] && state_of[s] != ST_S) begin
                  if (!moesi) begin
                     leave_line(s, ST_S);
                     dirty_of[s] = 1'b0;
                     state_of[s] = ST_S;
                  end else if (state_of[s] == ST_E) begin
                     state_of[s] = ST_S;
                  end else begin
                     state_of[s] = ST_O;
                  end
               end
            end
            leave_line(mine, ST_I);
            tag_of[mine] = r.address;
            state_of[mine] = ST_S;
            dirty_of[mine] = dd;
            value_of[mine] = v;
            res.fill_source = FILL_REMOTE;
            res.source_cache = first[1:0];
         end else if (!hit) begin
            leave_line(mine, ST_I);
            tag_of[mine] = r.address;
            state_of[mine] = ST_E;
            dirty_of[mine] = 1'b0;
            value_of[mine] = memory[r.address];
            res.fill_source = FILL_MEM;
         end
      end else begin
         for (int i = 0; i < 4; i++) begin
            s = i * 4 + idx;
            if (mask[i]) begin
               leave_line(s, ST_I);
               state_of[s] = ST_I;
               dirty_of[s] = 1'b0;
            end
         end
         if (!hit) leave_line(mine, ST_I);
         tag_of[mine] = r.address;
         state_of[mine] = ST_M;
         dirty_of[mine] = 1'b1;
         value_of[mine] = r.data;
      end
      res.line_data = value_of[mine];
      res.line_state = state_of[mine];
      res.local_hit = hit;
      res.holder_mask = mask;
      res.writebacks = wb_count[2:0];
      res.invalidations = inv_count[2:0];
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            tag_of[i] = '0;
            state_of[i] = ST_I;
            dirty_of[i] = 1'b0;
            value_of[i] = '0;
            memory[i] = '0;
         end
         moesi = 1'b0;
         expected_rsps.delete();
      end else begin
         if (csr_valid && csr_ready) moesi = csr_data;
         if (req_valid && !req_stall) expected_rsps.push_back(coherence_result(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               failures++;
            end else begin
               e = expected_rsps.pop_front();
               if (e.line_data !== rsp_data.line_data
                   || e.line_state !== rsp_data.line_state
                   || e.local_hit !== rsp_data.local_hit
                   || e.holder_mask !== rsp_data.holder_mask
                   || e.fill_source !== rsp_data.fill_source
                   || e.source_cache !== rsp_data.source_cache
                   || e.writebacks !== rsp_data.writebacks
                   || e.invalidations !== rsp_data.invalidations) begin
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
                  failures++;
               end
            end
         end
      end
      pending = expected_rsps.size();
   end

   initial begin
      failures = 0;
      pending = 0;
   end

endmodule

// ===== tb/snoop_coherence_mesi_moesi_test.sv =====
`timescale 1ns / 1ps
module snoop_coherence_mesi_moesi_test;
   import scm_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic    csr_data;
   int      failures;
   int      pending;
   int      cycles;
   logic    idle_on;
   int      stall_left;

   snoop_coherence_mesi_moesi dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   snoop_coherence_mesi_moesi_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .failures(failures), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("[snoop_coherence_mesi_moesi] ERROR");
         $finish;
      end
   end

   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
      return $urandom_range(0, 2);
   endfunction

   always @(negedge clock) begin
      if (!idle_on) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= $urandom_range(0, 2) == 0;
         stall_left <= gap_length();
      end
   end

   task automatic send(logic [1:0] kind, logic [1:0] core, logic [3:0] address,
                       logic [31:0] data);
      int n;
      req_data <= '{kind: kind, core: core, address: address, data: data};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      n = idle_on ? gap_length() : 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_mode(logic mode);
      drain();
      csr_data <= mode;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic directed_set();
      send(KIND_READ, 2'd0, 4'd0, 32'd0);
      send(KIND_READ, 2'd1, 4'd0, 32'd0);
      send(KIND_WRITE, 2'd2, 4'd0, 32'h1234_5678);
      send(KIND_READ, 2'd3, 4'd0, 32'd0);
      send(KIND_READ, 2'd1, 4'd0, 32'd0);
      send(KIND_READ, 2'd3, 4'd0, 32'd0);
      send(KIND_WRITE, 2'd2, 4'd4, 32'h7fff_ffff);
      send(KIND_WRITE, 2'd2, 4'd8, 32'h8000_0000);
      send(KIND_WRITE, 2'd3, 4'd15, 32'hffff_ffff);
      send(KIND_WRITE, 2'd3, 4'd15, 32'h0);
      send(2'd3, 2'd3, 4'd15, 32'hffff_ffff);
      send(KIND_PRELOAD, 2'd0, 4'd15, 32'h8000_0001);
   endtask

   task automatic random_set(int count);
      logic [1:0] kind;
      int r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         kind = r < 45 ? KIND_READ : r < 85 ? KIND_WRITE : r < 97 ? KIND_PRELOAD : 2'd3;
         send(kind, 2'($urandom_range(0, 3)),
              4'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 15)),
              32'($urandom));
         if (i == count / 2) begin
            req_valid <= 1'b0;
            wait (pending == 0);
            @(negedge clock);
         end
      end
   endtask

   initial begin
      cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      idle_on = 1'b0;
      stall_left = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int a = 0; a < 16; a++) send(KIND_PRELOAD, 2'd0, a[3:0], 32'($urandom));
      directed_set();
      set_mode(1'b1);
      directed_set();
      for (int p = 0; p < 4; p++) begin
         set_mode(p[0]);
         idle_on <= p != 2;
         random_set(300);
      end
      drain();
      if (failures == 0) begin
         $display("[snoop_coherence_mesi_moesi] OK");
      end else begin
         $display("[snoop_coherence_mesi_moesi] ERROR");
      end
      $finish;
   end

endmodule

// ===== snoop_coherence_mesi_moesi.f =====
+incdir+hdl
hdl/scm_pkg.sv
hdl/scm_ctrl.sv
hdl/scm_datapath.sv
hdl/snoop_coherence_mesi_moesi.sv
tb/snoop_coherence_mesi_moesi_checker.sv
tb/snoop_coherence_mesi_moesi_test.sv
